// ----- sv/iir3_pkg.sv -----
// ----------------------------------------------------------------------------
// iir3_pkg: shared types and constants of the third-order IIR filter
// Field widths, register indexes and coefficient reset values.
// ----------------------------------------------------------------------------
package iir3_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int HIST_W     = 32;
   localparam int NUM_TAPS   = 3;
   localparam int NUM_REGS   = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int FF_PROD_W  = COEF_W + SAMPLE_W;
   localparam int FB_PROD_W  = COEF_W + HIST_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [HIST_W-1:0]   hist_type;

   // Coefficient pair used by one delay tap
   typedef struct packed {
      coef_type ff;
      coef_type fb;
   } tap_coef_type;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FF_COEF_0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FF_COEF_1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FF_COEF_2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_FF_COEF_3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_FB_COEF_1 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_FB_COEF_2 = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_FB_COEF_3 = 3'd6;

   localparam coef_type COEF_RESET [NUM_REGS] = '{
      18'sd469, 18'sd1407, 18'sd1407, 18'sd469,
      -18'sd18987, 18'sd15729, -18'sd3473
   };

endpackage

// ----- sv/iir_third_order_filter.sv -----
// ----------------------------------------------------------------------------
// iir_third_order_filter: third-order direct form I IIR filter
// Seven Q3.14 coefficients, 32-bit saturating output history, 16-bit
// saturated output truncated toward zero with a clip flag.
//
//   port group | dir    | handshake         | payload
//   req_       | in     | req_valid/ready   | req_sample_in
//   rsp_       | out    | rsp_valid/ready   | rsp_sample_out, rsp_saturated
//   csr_       | in     | csr_we            | csr_addr, csr_wdata
//
// One item per cycle while the output is not stalled; each result is formed
// combinationally and loaded into the output register on its accept. The rate
// is set by the output history loop: new output -> three feedback multipliers
// -> cell adder chain -> next output, closed through the y_ff registers.
// Reset clears the histories and loads the default coefficients.
// A stalled result holds the output register; a new item is taken in the
// cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module iir_third_order_filter #(
   parameter int COEF_FRAC_BITS = 14,
   parameter int HIST_FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [iir3_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [iir3_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_saturated,
   input  logic                                 csr_we,
   input  logic [iir3_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [iir3_pkg::COEF_W-1:0]          csr_wdata
);

   localparam int FF_SUM_W = iir3_pkg::FF_PROD_W + 2 + HIST_FRAC_BITS;
   localparam int FB_SUM_W = iir3_pkg::FB_PROD_W + 2;
   localparam int ACC_W    = ((FF_SUM_W > FB_SUM_W) ? FF_SUM_W : FB_SUM_W) + 1;
   localparam logic [ACC_W-1:0] COEF_MASK =
      ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
   localparam logic [iir3_pkg::HIST_W-1:0] HIST_MASK =
      iir3_pkg::HIST_W'((64'd1 << HIST_FRAC_BITS) - 64'd1);

   iir3_pkg::coef_type coef_ff [iir3_pkg::NUM_REGS];
   iir3_pkg::coef_type coef_in [iir3_pkg::NUM_REGS];

   logic                                  req_accept;
   logic                                  rsp_valid_ff, rsp_valid_in;
   iir3_pkg::sample_type                  rsp_sample_ff, rsp_sample_in;
   logic                                  rsp_sat_ff, rsp_sat_in;

   iir3_pkg::sample_type                  x_chain [iir3_pkg::NUM_TAPS+1];
   iir3_pkg::hist_type                    y_chain [iir3_pkg::NUM_TAPS+1];
   logic signed [ACC_W-1:0]               sum_chain [iir3_pkg::NUM_TAPS+1];
   logic signed [iir3_pkg::FF_PROD_W-1:0] b0_prod;

   logic signed [ACC_W-1:0]               acc_q;
   logic                                  hist_clip;
   iir3_pkg::hist_type                    yh;
   iir3_pkg::hist_type                    ys_q;
   logic                                  out_clip;
   iir3_pkg::sample_type                  ys;

   // Coefficient registers
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_addr) inside
            iir3_pkg::REG_FF_COEF_0, iir3_pkg::REG_FF_COEF_1,
            iir3_pkg::REG_FF_COEF_2, iir3_pkg::REG_FF_COEF_3,
            iir3_pkg::REG_FB_COEF_1, iir3_pkg::REG_FB_COEF_2,
            iir3_pkg::REG_FB_COEF_3: begin
               coef_in[csr_addr] = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= iir3_pkg::COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Take an item whenever the output register is free or being emptied
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Current-sample term feeds the head of the cell chain
   always_comb begin
      b0_prod      = coef_ff[iir3_pkg::REG_FF_COEF_0] * req_sample_in;
      sum_chain[0] = ACC_W'(b0_prod) <<< HIST_FRAC_BITS;
      x_chain[0]   = req_sample_in;
      y_chain[0]   = yh;
   end

   // Row of delay taps
   for (genvar k = 0; k < iir3_pkg::NUM_TAPS; k++) begin : g_tap
      iir3_pkg::tap_coef_type tap_coef;

      assign tap_coef.ff = coef_ff[1 + k];
      assign tap_coef.fb = coef_ff[iir3_pkg::NUM_TAPS + 1 + k];

      iir3_cell #(
         .HIST_FRAC_BITS (HIST_FRAC_BITS),
         .ACC_W          (ACC_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (req_accept),
         .x_in    (x_chain[k]),
         .y_in    (y_chain[k]),
         .coef    (tap_coef),
         .sum_in  (sum_chain[k]),
         .x_out   (x_chain[k+1]),
         .y_out   (y_chain[k+1]),
         .sum_out (sum_chain[k+1])
      );
   end

   // Scale to the history format toward zero, then clip to 32 bits
   always_comb begin
      acc_q = sum_chain[iir3_pkg::NUM_TAPS] >>> COEF_FRAC_BITS;
      if (sum_chain[iir3_pkg::NUM_TAPS][ACC_W-1] &&
          ((sum_chain[iir3_pkg::NUM_TAPS] & COEF_MASK) != '0)) begin
         acc_q = acc_q + ACC_W'(1);
      end
      hist_clip = 1'b0;
      yh        = acc_q[iir3_pkg::HIST_W-1:0];
      if (acc_q[ACC_W-1] && !(&acc_q[ACC_W-1:iir3_pkg::HIST_W-1])) begin
         hist_clip = 1'b1;
         yh        = {1'b1, {(iir3_pkg::HIST_W-1){1'b0}}};
      end else if (!acc_q[ACC_W-1] && (|acc_q[ACC_W-1:iir3_pkg::HIST_W-1])) begin
         hist_clip = 1'b1;
         yh        = {1'b0, {(iir3_pkg::HIST_W-1){1'b1}}};
      end
   end

   // Drop the history fraction toward zero, then clip to 16 bits
   always_comb begin
      ys_q = yh >>> HIST_FRAC_BITS;
      if (yh[iir3_pkg::HIST_W-1] && ((yh & HIST_MASK) != '0)) begin
         ys_q = ys_q + iir3_pkg::HIST_W'(1);
      end
      out_clip = 1'b0;
      ys       = ys_q[iir3_pkg::SAMPLE_W-1:0];
      if (ys_q[iir3_pkg::HIST_W-1] &&
          !(&ys_q[iir3_pkg::HIST_W-1:iir3_pkg::SAMPLE_W-1])) begin
         out_clip = 1'b1;
         ys       = {1'b1, {(iir3_pkg::SAMPLE_W-1){1'b0}}};
      end else if (!ys_q[iir3_pkg::HIST_W-1] &&
                   (|ys_q[iir3_pkg::HIST_W-1:iir3_pkg::SAMPLE_W-1])) begin
         out_clip = 1'b1;
         ys       = {1'b0, {(iir3_pkg::SAMPLE_W-1){1'b1}}};
      end
   end

   // Output register: load on accept, hold while stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = ys;
         rsp_sat_in    = hist_clip || out_clip;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // Every accepted item leaves a result in the output register
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_accept)
      else $error("waiting result overwritten");

   // The first cell takes the accepted sample into the input history
   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (x_chain[1] == $past(req_sample_in)))
      else $error("input history did not advance");

   // Histories hold while no item is accepted
   a_history_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(x_chain[1]) && $stable(y_chain[1])))
      else $error("history moved without an item");

endmodule

// ----- sv/iir3_cell.sv -----
// ----------------------------------------------------------------------------
// iir3_cell: one delay tap of the direct form I filter
// Holds one past input and one past output, forms the tap's weighted term
// and adds it to the partial sum coming from the neighbouring cell.
// ----------------------------------------------------------------------------
module iir3_cell #(
   parameter int HIST_FRAC_BITS = 8,
   parameter int ACC_W          = 54
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  iir3_pkg::sample_type      x_in,
   input  iir3_pkg::hist_type        y_in,
   input  iir3_pkg::tap_coef_type    coef,
   input  logic signed [ACC_W-1:0]   sum_in,
   output iir3_pkg::sample_type      x_out,
   output iir3_pkg::hist_type        y_out,
   output logic signed [ACC_W-1:0]   sum_out
);

   iir3_pkg::sample_type                   x_ff, x_shift_in;
   iir3_pkg::hist_type                     y_ff, y_shift_in;
   logic signed [iir3_pkg::FF_PROD_W-1:0]  ff_prod;
   logic signed [iir3_pkg::FB_PROD_W-1:0]  fb_prod;
   logic signed [ACC_W-1:0]                ff_term;
   logic signed [ACC_W-1:0]                fb_term;

   // Advance the delay line on each accepted item
   always_comb begin
      x_shift_in = shift ? x_in : x_ff;
      y_shift_in = shift ? y_in : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_shift_in;
         y_ff <= y_shift_in;
      end
   end

   // Weighted tap term, feed-forward scaled up to the history format
   always_comb begin
      ff_prod = coef.ff * x_ff;
      fb_prod = coef.fb * y_ff;
      ff_term = ACC_W'(ff_prod) <<< HIST_FRAC_BITS;
      fb_term = ACC_W'(fb_prod);
      sum_out = sum_in + ff_term - fb_term;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule
